/* hw/rtl/vdbq_pkg.sv */
// Package for the voxel dilation box query block.
// Holds operation codes, the state machine type and the default chunk size constant.
// No dependencies.
`default_nettype none
package vdbq_pkg;
	localparam int CHUNK_LOG2_DEF = 3;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_BUILD,
		ST_QUERY,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

/* hw/rtl/vdbq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module vdbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/voxel_dilation_box_query.sv */
// Voxel dilation box query top level: handshake, control sequencer and mask store.
// Depends on vdbq_pkg and vdbq_ram.
`default_nettype none
// A load word reads, modifies and writes back one staging row (states LOAD_RD and
// LOAD_WR; a cell out of range is read but not written), a query is evaluated in state
// QUERY, and a build walks the staging store once, one row per cycle, over all (CS+2)^2
// rows; the single staging RAM port sets this pace. The result word sits in an output
// register; the next word is taken once it has been delivered. Loads give no result word.
module voxel_dilation_box_query
	import vdbq_pkg::*;
#(
	parameter int CHUNK_LOG2 = CHUNK_LOG2_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// operation[1:0], cell_x[5:2], cell_y[9:6], cell_z[13:10], material[21:14],
	// box_min_x[32:22], box_min_y[43:33], box_min_z[54:44], box_max_x[65:55],
	// box_max_y[76:66], box_max_z[87:77]
	input  wire logic [87:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// chunk_present[0], touches_solid[1], touches_water[2]
	output logic [7:0]       m_tdata
);
	localparam int CS = 1 << CHUNK_LOG2;
	localparam int SZ = CS + 2;
	localparam int NR = SZ * SZ;
	localparam int AW = $clog2(NR);
	localparam int CW = $clog2(SZ);
	localparam int MW = CS * CS;

	logic [7:0] water_q;
	state_t state_q, state_d;
	logic [87:0] word_q;
	logic [CW-1:0] ry_q, rz_q;
	logic rd_v_s1;
	logic [CW-1:0] ry_s1, rz_s1;
	logic [AW-1:0] raddr;
	logic [2*SZ-1:0] rdata, wdata_c;
	logic we_c;
	logic [MW-1:0] solid_q [CS];
	logic [MW-1:0] water_q2 [CS];
	logic present_q, any_q;
	logic [2:0] res_q;
	logic [CW-1:0] lx, ly, lz;
	logic load_ok;

	assign lx = CW'(word_q[5:2]);
	assign ly = CW'(word_q[9:6]);
	assign lz = CW'(word_q[13:10]);
	assign load_ok = (word_q[5:2] < 4'(SZ)) && (word_q[9:6] < 4'(SZ))
		&& (word_q[13:10] < 4'(SZ));

	always_comb begin
		raddr = AW'(ly) * AW'(SZ) + AW'(lz);
		if (state_q == ST_BUILD) begin
			raddr = AW'(ry_q) * AW'(SZ) + AW'(rz_q);
		end
	end

	always_comb begin
		logic [2*SZ-1:0] r;
		r = rdata;
		r[lx] = (word_q[21:14] > water_q);
		r[SZ + 32'(lx)] = (word_q[21:14] == water_q);
		wdata_c = r;
		we_c = (state_q == ST_LOAD_WR);
	end

	vdbq_ram #(.WIDTH(2*SZ), .DEPTH(NR)) u_stage (
		.clk(clk), .we(we_c), .waddr(raddr), .wdata(wdata_c),
		.raddr(raddr), .rdata(rdata)
	);

	logic build_last;
	assign build_last = (ry_q == CW'(SZ-1)) && (rz_q == CW'(SZ-1));

	// The last row's data arrives in the cycle after its address; the build ends there.
	logic last_s1, any_fin;
	assign last_s1 = rd_v_s1 && (ry_s1 == CW'(SZ-1)) && (rz_s1 == CW'(SZ-1));
	assign any_fin = any_q | (|rdata);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (op_t'(s_tdata[1:0]))
						OP_LOAD:  state_d = ST_LOAD_RD;
						OP_BUILD: state_d = ST_BUILD;
						OP_QUERY: state_d = ST_QUERY;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD_RD: state_d = load_ok ? ST_LOAD_WR : ST_IDLE;
			ST_LOAD_WR: state_d = ST_IDLE;
			ST_BUILD:   state_d = last_s1 ? ST_OUT : ST_BUILD;
			ST_QUERY:   state_d = ST_OUT;
			ST_OUT:     state_d = m_tready ? ST_IDLE : ST_OUT;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_OUT);
		m_tdata = {5'd0, res_q};
	end

	// Query: clamp the bounds and test the slices directly.
	function automatic logic [CW-1:0] clampv(input logic [10:0] v);
		logic [CW-1:0] r;
		if (v[10]) r = '0;
		else if (v > 11'(CS-1)) r = CW'(CS-1);
		else r = CW'(v);
		return r;
	endfunction

	logic qs_c, qw_c;
	always_comb begin
		logic [CW-1:0] x0, y0, z0, x1, y1, z1;
		logic [MW-1:0] m;
		x0 = clampv(word_q[32:22]);
		y0 = clampv(word_q[43:33]);
		z0 = clampv(word_q[54:44]);
		x1 = clampv(word_q[65:55]);
		y1 = clampv(word_q[76:66]);
		z1 = clampv(word_q[87:77]);
		m = '0;
		for (int z = 0; z < CS; z++) begin
			for (int x = 0; x < CS; x++) begin
				m[z*CS+x] = (CW'(x) >= x0) && (CW'(x) <= x1)
					&& (CW'(z) >= z0) && (CW'(z) <= z1);
			end
		end
		qs_c = 1'b0;
		qw_c = 1'b0;
		for (int y = 0; y < CS; y++) begin
			if ((CW'(y) >= y0) && (CW'(y) <= y1)) begin
				qs_c = qs_c | (|(solid_q[y] & m));
				qw_c = qw_c | (|(water_q2[y] & m));
			end
		end
		if (!present_q || x0 > x1 || y0 > y1 || z0 > z1) begin
			qs_c = 1'b0;
			qw_c = 1'b0;
		end
	end

	// Build: row (y,z) dilated in x contributes to outputs y-2..y, z-2..z (shifted by one).
	logic [SZ-1:0] ds, dw;
	always_comb begin
		ds = (rdata[SZ-1:0] | (rdata[SZ-1:0] << 1) | (rdata[SZ-1:0] >> 1));
		dw = (rdata[2*SZ-1:SZ] | (rdata[2*SZ-1:SZ] << 1) | (rdata[2*SZ-1:SZ] >> 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			water_q <= 8'd1;
			present_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			for (int i = 0; i < CS; i++) begin
				solid_q[i] <= '0;
				water_q2[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				water_q <= cfg_wdata;
			end
			rd_v_s1 <= (state_q == ST_BUILD) && !last_s1;
			if (state_q == ST_IDLE && s_tvalid && s_tdata[1:0] == OP_BUILD) begin
				for (int i = 0; i < CS; i++) begin
					solid_q[i] <= '0;
					water_q2[i] <= '0;
				end
			end
			if (rd_v_s1) begin
				for (int y = 0; y < CS; y++) begin
					for (int z = 0; z < CS; z++) begin
						if (32'(ry_s1) >= y && 32'(ry_s1) <= y + 2
							&& 32'(rz_s1) >= z && 32'(rz_s1) <= z + 2) begin
							solid_q[y][z*CS +: CS] <= solid_q[y][z*CS +: CS] | ds[CS:1];
							water_q2[y][z*CS +: CS] <= water_q2[y][z*CS +: CS] | dw[CS:1];
						end
					end
				end
			end
			if (state_q == ST_BUILD && last_s1) begin
				present_q <= any_fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_q <= s_tdata;
			ry_q <= '0;
			rz_q <= '0;
			any_q <= 1'b0;
		end
		if (state_q == ST_BUILD) begin
			ry_s1 <= ry_q;
			rz_s1 <= rz_q;
			if (!build_last) begin
				if (rz_q == CW'(SZ-1)) begin
					rz_q <= '0;
					ry_q <= ry_q + 1'b1;
				end else begin
					rz_q <= rz_q + 1'b1;
				end
			end
		end
		if (rd_v_s1 && (|rdata)) begin
			any_q <= 1'b1;
		end
		if (state_q == ST_QUERY) begin
			res_q <= {qw_c, qs_c, present_q};
		end
		if (state_q == ST_BUILD && last_s1) begin
			res_q <= {2'b00, any_fin};
		end
	end

`ifndef SYNTH
	a_ready_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	a_build_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && word_q[1:0] == OP_BUILD |-> m_tdata[2:1] == 2'b00)
		else $error("build result carries touch flags");
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'b00)
		else $error("absent chunk touched");
`endif
endmodule
`default_nettype wire

/* tb/voxel_dilation_box_query_test.sv */
// Self-checking testbench for the voxel dilation box query block.
// Drives load, build and query words, predicts every result word and compares it.
// Depends on vdbq_pkg and the voxel_dilation_box_query RTL.
`default_nettype none
module voxel_dilation_box_query_test
	import vdbq_pkg::*;
;
	localparam int CS = 8;
	localparam int SZ = CS + 2;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [10:0] max_z, max_y, max_x, min_z, min_y, min_x;
		logic [7:0] material;
		logic [3:0] cz, cy, cx;
		op_t op;
	} word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_wdata = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [87:0] s_tdata = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [7:0] m_tdata;

	voxel_dilation_box_query uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Predictor state.
	logic [7:0] water_code = 8'd1;
	logic [SZ-1:0] cube_solid [SZ][SZ];
	logic [SZ-1:0] cube_water [SZ][SZ];
	logic [63:0] solid_slice [CS];
	logic [63:0] water_slice [CS];
	logic present = 0;

	word_t pending_words[$];
	logic [2:0] expected_results[$];
	int send_idle = 0, recv_stall = 0;
	bit failed = 0;
	longint cycles = 0;

	task automatic queue_word(word_t w);
		pending_words = {pending_words, w};
	endtask

	task automatic expect_result(logic [2:0] r);
		expected_results = {expected_results, r};
	endtask

	function automatic int clamp_axis(logic [10:0] v);
		if ($signed(v) < 0) return 0;
		if ($signed(v) > CS - 1) return CS - 1;
		return int'($signed(v));
	endfunction

	function automatic logic [SZ-1:0] spread_x(logic [SZ-1:0] r);
		return r | (r << 1) | (r >> 1);
	endfunction

	task automatic predict_word(word_t w);
		logic [SZ-1:0] sr, wr;
		logic [63:0] s, wt, mask;
		int x0, y0, z0, x1, y1, z1;
		bit any, ts, tw;
		case (w.op)
			OP_LOAD: begin
				if (w.cx < SZ && w.cy < SZ && w.cz < SZ) begin
					cube_solid[w.cy][w.cz][w.cx] = w.material > water_code;
					cube_water[w.cy][w.cz][w.cx] = w.material == water_code;
				end
			end
			OP_BUILD: begin
				any = 0;
				for (int y = 0; y < SZ; y++)
					for (int z = 0; z < SZ; z++)
						if (cube_solid[y][z] != 0 || cube_water[y][z] != 0) any = 1;
				for (int y = 0; y < CS; y++) begin
					s = 0;
					wt = 0;
					for (int z = 0; z < CS; z++) begin
						sr = 0;
						wr = 0;
						for (int dy = 0; dy < 3; dy++)
							for (int dz = 0; dz < 3; dz++) begin
								sr |= spread_x(cube_solid[y+dy][z+dz]);
								wr |= spread_x(cube_water[y+dy][z+dz]);
							end
						s[z*CS +: CS] = sr[CS:1];
						wt[z*CS +: CS] = wr[CS:1];
					end
					solid_slice[y] = any ? s : 64'd0;
					water_slice[y] = any ? wt : 64'd0;
				end
				present = any;
				expect_result({2'b00, any});
			end
			OP_QUERY: begin
				x0 = clamp_axis(w.min_x); y0 = clamp_axis(w.min_y); z0 = clamp_axis(w.min_z);
				x1 = clamp_axis(w.max_x); y1 = clamp_axis(w.max_y); z1 = clamp_axis(w.max_z);
				ts = 0;
				tw = 0;
				if (present && x0 <= x1 && y0 <= y1 && z0 <= z1) begin
					mask = 0;
					for (int z = z0; z <= z1; z++)
						for (int x = x0; x <= x1; x++) mask[z*CS + x] = 1;
					for (int y = y0; y <= y1; y++) begin
						if ((solid_slice[y] & mask) != 0) ts = 1;
						if ((water_slice[y] & mask) != 0) tw = 1;
					end
				end
				expect_result({tw, ts, present});
			end
			default: ;
		endcase
	endtask

	// Driver.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!s_tvalid || s_tready) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
				s_tdata <= pending_words.pop_front();
				s_tvalid <= 1;
			end else begin
				s_tvalid <= 0;
			end
		end
		m_tready <= $urandom_range(99) >= recv_stall;
	end

	// Monitor.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) predict_word(word_t'(s_tdata));
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %b",
					$time, m_tdata[2:0]);
				failed = 1;
			end else begin
				if (m_tdata[2:0] !== expected_results[0]) begin
					$display("%0t: mismatch (water,solid,present) expected %b actual %b",
						$time, expected_results[0], m_tdata[2:0]);
					failed = 1;
				end
				void'(expected_results.pop_front());
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [10:0] rand_bound();
		case ($urandom_range(5))
			0: return 11'($urandom);
			1: return 11'($signed($urandom_range(20)) - 10);
			default: return 11'($urandom_range(7));
		endcase
	endfunction

	function automatic word_t make_load(int x, int y, int z, int m);
		word_t w = '0;
		w.op = OP_LOAD;
		w.cx = 4'(x); w.cy = 4'(y); w.cz = 4'(z); w.material = 8'(m);
		return w;
	endfunction

	function automatic word_t make_query(logic [10:0] a, b, c, d, e, f);
		word_t w = '0;
		w.op = OP_QUERY;
		w.min_x = a; w.min_y = b; w.min_z = c; w.max_x = d; w.max_y = e; w.max_z = f;
		return w;
	endfunction

	function automatic word_t make_build();
		word_t w = '0;
		w.op = OP_BUILD;
		return w;
	endfunction

	task automatic drain();
		while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_water_code(logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		water_code = v;
	endtask

	// Fill the whole bordered cube: each cell gets a random material code with a chance of bias percent, else code zero.
	task automatic queue_cube_fill(int bias);
		for (int y = 0; y < SZ; y++)
			for (int z = 0; z < SZ; z++)
				for (int x = 0; x < SZ; x++)
					queue_word(make_load(x, y, z,
						$urandom_range(99) < bias ? $urandom : 0));
	endtask

	task automatic queue_random_mix(int n);
		word_t w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: queue_word(make_build());
				1: begin
					w = word_t'({$urandom, $urandom, 24'($urandom)});
					w.op = OP_NONE;
					queue_word(w);
				end
				2, 3, 4, 5, 6, 7, 8: queue_word(make_load($urandom_range(9),
					$urandom_range(9), $urandom_range(9), $urandom));
				9: queue_word(make_load($urandom_range(15),
					$urandom_range(15), $urandom_range(15), $urandom));
				default: queue_word(make_query(rand_bound(), rand_bound(),
					rand_bound(), rand_bound(), rand_bound(), rand_bound()));
			endcase
		end
	endtask

	initial begin
		logic [7:0] codes [4] = '{8'd1, 8'd0, 8'd255, 8'd128};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: queries on an absent chunk, an empty cube, one solid and one water corner cell,
		// out-of-range loads, unused operation, empty and far-out boxes.
		queue_word(make_query(0, 0, 0, 7, 7, 7));
		queue_cube_fill(0);
		queue_word(make_build());
		queue_word(make_query(11'h400, 11'h400, 11'h400, 11'h3FF, 11'h3FF, 11'h3FF));
		queue_word(make_load(9, 9, 9, 255));
		queue_word(make_load(0, 0, 0, 1));
		queue_word(make_load(15, 0, 0, 255));
		queue_word(make_load(0, 10, 3, 255));
		begin
			word_t w = word_t'({$urandom, $urandom, 24'hFFFFFF});
			w.op = OP_NONE;
			queue_word(w);
		end
		queue_word(make_build());
		queue_word(make_query(0, 0, 0, 7, 7, 7));
		queue_word(make_query(7, 7, 7, 7, 7, 7));
		queue_word(make_query(0, 0, 0, 0, 0, 0));
		queue_word(make_query(11'h3FF, 11'h3FF, 11'h3FF, 11'h400, 11'h400, 11'h400));
		queue_word(make_query(5, 0, 0, 2, 7, 7));
		queue_word(make_query(11'h7F8, 11'h7F8, 11'h7F8, 11'h3F8, 11'h3F8, 11'h3F8));
		queue_word(make_query(0, 0, 0, 5, 5, 5));
		drain();

		// Every cell is loaded by now, so later builds never read an unwritten row.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 66; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 66; end
				default: begin send_idle = 27; recv_stall = 27; end
			endcase
			write_water_code(codes[phase]);
			queue_word(make_build());
			queue_random_mix(95);
			drain();
		end

		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
